>>> design/cbn_pkg.sv
// package for contact basis from normal unit
// widths, pipeline payload types and saturation helper; no dependencies
package cbn_pkg;
  localparam int FracBits  = 16;
  localparam int FieldW    = 18;
  localparam int SqW       = 2 * FieldW;
  localparam int SumW      = SqW + 1;
  localparam int RootW     = (SumW + 1) / 2;
  localparam int DivNumW   = FieldW + FracBits;
  localparam int QuotW     = DivNumW;
  localparam int ProdW     = 2 * FieldW + 1;

  localparam logic signed [FieldW-1:0] FieldMax = {1'b0, {(FieldW-1){1'b1}}};
  localparam logic signed [FieldW-1:0] FieldMin = {1'b1, {(FieldW-1){1'b0}}};

  typedef logic signed [FieldW-1:0] field_t;

  typedef struct packed {
    field_t nx;
    field_t ny;
    field_t nz;
    logic   use_x;
    logic   degen;
  } hdr_t;

  function automatic field_t sat_quot(input logic neg, input logic [QuotW-1:0] mag);
    logic [QuotW:0] lim;
    begin
      lim = {1'b0, mag};
      if (!neg) begin
        if (mag > QuotW'(FieldMax)) sat_quot = FieldMax;
        else sat_quot = field_t'(mag);
      end else begin
        if (lim > (QuotW+1)'(2 ** (FieldW-1))) sat_quot = FieldMin;
        else sat_quot = field_t'(-$signed(lim));
      end
    end
  endfunction
endpackage

>>> design/cbn_sqrt_pipe.sv
// pipelined floor integer square root, one result bit per stage
// depends on cbn_pkg
module cbn_sqrt_pipe import cbn_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [SumW-1:0]  rad_i,
  input  hdr_t             hdr_i,
  output logic             valid_o,
  output logic [RootW-1:0] root_o,
  output hdr_t             hdr_o
);
  localparam int RadW = 2 * RootW;

  logic             vld_q  [RootW+1];
  logic [RadW-1:0]  rem_q  [RootW+1];
  logic [RootW-1:0] res_q  [RootW+1];
  logic [RadW-1:0]  rad_q  [RootW+1];
  hdr_t             hdr_q  [RootW+1];

  always_comb begin
    vld_q[0] = valid_i;
    rem_q[0] = '0;
    res_q[0] = '0;
    rad_q[0] = RadW'(rad_i);
    hdr_q[0] = hdr_i;
  end

  for (genvar s = 0; s < RootW; s++) begin : g_stage
    logic [RadW-1:0]  rem_d;
    logic [RadW-1:0]  trial;
    logic [RootW-1:0] res_d;
    always_comb begin
      rem_d = {rem_q[s][RadW-3:0], rad_q[s][RadW-1:RadW-2]};
      trial = {res_q[s], 2'b01};
      if (rem_d >= trial) begin
        rem_d = rem_d - trial;
        res_d = {res_q[s][RootW-2:0], 1'b1};
      end else begin
        res_d = {res_q[s][RootW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[s+1] <= 1'b0;
      else vld_q[s+1] <= vld_q[s];
    end
    always_ff @(posedge clk_i) begin
      rem_q[s+1] <= rem_d;
      res_q[s+1] <= res_d;
      rad_q[s+1] <= {rad_q[s][RadW-3:0], 2'b00};
      hdr_q[s+1] <= hdr_q[s];
    end
  end

  assign valid_o = vld_q[RootW];
  assign root_o  = res_q[RootW];
  assign hdr_o   = hdr_q[RootW];
endmodule

>>> design/cbn_div_pipe.sv
// pipelined restoring divider for two numerators over a shared root
// depends on cbn_pkg
module cbn_div_pipe import cbn_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [RootW-1:0]   root_i,
  input  logic [FieldW-1:0]  mag_a_i,
  input  logic [FieldW-1:0]  mag_b_i,
  input  hdr_t               hdr_i,
  output logic               valid_o,
  output logic [QuotW-1:0]   quot_a_o,
  output logic [QuotW-1:0]   quot_b_o,
  output hdr_t               hdr_o
);
  localparam int RemW = RootW + 1;

  logic               vld_q [DivNumW+1];
  logic [RootW-1:0]   den_q [DivNumW+1];
  logic [DivNumW-1:0] na_q  [DivNumW+1];
  logic [DivNumW-1:0] nb_q  [DivNumW+1];
  logic [RemW-1:0]    ra_q  [DivNumW+1];
  logic [RemW-1:0]    rb_q  [DivNumW+1];
  hdr_t               hdr_q [DivNumW+1];

  always_comb begin
    vld_q[0] = valid_i;
    den_q[0] = root_i;
    na_q[0]  = {mag_a_i, {FracBits{1'b0}}};
    nb_q[0]  = {mag_b_i, {FracBits{1'b0}}};
    ra_q[0]  = '0;
    rb_q[0]  = '0;
    hdr_q[0] = hdr_i;
  end

  for (genvar s = 0; s < DivNumW; s++) begin : g_stage
    logic [RemW:0]      ta, tb;
    logic [RemW-1:0]    ra_d, rb_d;
    logic [DivNumW-1:0] na_d, nb_d;
    always_comb begin
      ta = {ra_q[s], na_q[s][DivNumW-1]};
      tb = {rb_q[s], nb_q[s][DivNumW-1]};
      na_d = {na_q[s][DivNumW-2:0], 1'b0};
      nb_d = {nb_q[s][DivNumW-2:0], 1'b0};
      if (ta >= (RemW+1)'(den_q[s])) begin
        ta = ta - (RemW+1)'(den_q[s]);
        na_d[0] = 1'b1;
      end
      if (tb >= (RemW+1)'(den_q[s])) begin
        tb = tb - (RemW+1)'(den_q[s]);
        nb_d[0] = 1'b1;
      end
      ra_d = ta[RemW-1:0];
      rb_d = tb[RemW-1:0];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[s+1] <= 1'b0;
      else vld_q[s+1] <= vld_q[s];
    end
    always_ff @(posedge clk_i) begin
      den_q[s+1] <= den_q[s];
      na_q[s+1]  <= na_d;
      nb_q[s+1]  <= nb_d;
      ra_q[s+1]  <= ra_d;
      rb_q[s+1]  <= rb_d;
      hdr_q[s+1] <= hdr_q[s];
    end
  end

  assign valid_o  = vld_q[DivNumW];
  assign quot_a_o = na_q[DivNumW];
  assign quot_b_o = nb_q[DivNumW];
  assign hdr_o    = hdr_q[DivNumW];
endmodule

>>> design/contact_basis_from_normal_unit.sv
// contact basis from normal unit, top level: front end, root, divide, cross product
// depends on cbn_pkg, cbn_sqrt_pipe, cbn_div_pipe
// a request passes stages 0 and 1, the one-bit-per-stage root and divider
// pipelines, then stages a, b and c before done_o
// throughput: one request per clock; busy is never high
// reset clears all valid bits; no result strobes until requests enter
module contact_basis_from_normal_unit import cbn_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  input  field_t       normal_x_i,
  input  field_t       normal_y_i,
  input  field_t       normal_z_i,
  output logic         done_o,
  output field_t       tan_a_x_o,
  output field_t       tan_a_y_o,
  output field_t       tan_a_z_o,
  output field_t       tan_b_x_o,
  output field_t       tan_b_y_o,
  output field_t       tan_b_z_o,
  output logic         degenerate_o
);
  assign busy = 1'b0;

  // stage 0: register request, pick branch
  logic v0_q;
  hdr_t h0_q;
  logic [FieldW-1:0] ax_abs, ay_abs;
  always_comb begin
    ax_abs = normal_x_i[FieldW-1] ? -normal_x_i : normal_x_i;
    ay_abs = normal_y_i[FieldW-1] ? -normal_y_i : normal_y_i;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else v0_q <= start && !busy;
  end
  always_ff @(posedge clk_i) begin
    h0_q.nx    <= normal_x_i;
    h0_q.ny    <= normal_y_i;
    h0_q.nz    <= normal_z_i;
    h0_q.use_x <= ax_abs > ay_abs;
    h0_q.degen <= (normal_x_i == '0) && (normal_y_i == '0) && (normal_z_i == '0);
  end

  // stage 1: squares
  logic v1_q;
  hdr_t h1_q;
  logic [SqW-1:0] sqz_q, sqp_q;
  field_t pick;
  assign pick = h0_q.use_x ? h0_q.nx : h0_q.ny;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= v0_q;
  end
  always_ff @(posedge clk_i) begin
    h1_q  <= h0_q;
    sqz_q <= SqW'($signed(h0_q.nz) * $signed(h0_q.nz));
    sqp_q <= SqW'(pick * pick);
  end

  logic [SumW-1:0] rad;
  assign rad = {1'b0, sqz_q} + {1'b0, sqp_q};

  logic             v2;
  logic [RootW-1:0] root;
  hdr_t             h2;
  cbn_sqrt_pipe u_sqrt (
    .clk_i, .rst_ni, .valid_i(v1_q), .rad_i(rad), .hdr_i(h1_q),
    .valid_o(v2), .root_o(root), .hdr_o(h2)
  );

  // numerators: a -> ax or ay slot, b -> az slot
  logic [FieldW-1:0] mag_a, mag_b;
  always_comb begin
    mag_a = h2.nz[FieldW-1] ? -h2.nz : h2.nz;
    mag_b = h2.use_x ? (h2.nx[FieldW-1] ? -h2.nx : h2.nx)
                     : (h2.ny[FieldW-1] ? -h2.ny : h2.ny);
  end
  // signs: a positive if use_x and nz>0, or !use_x and nz<0
  hdr_t h2s;
  logic neg_a, neg_b;
  assign neg_a = h2.use_x ? h2.nz[FieldW-1] : (h2.nz != '0 && !h2.nz[FieldW-1]);
  assign neg_b = h2.use_x ? (h2.nx != '0 && !h2.nx[FieldW-1]) : h2.ny[FieldW-1];

  logic [1:0] sgn_q [DivNumW+1];
  assign sgn_q[0] = {neg_a, neg_b};
  for (genvar s = 0; s < DivNumW; s++) begin : g_sgn
    always_ff @(posedge clk_i) sgn_q[s+1] <= sgn_q[s];
  end
  assign h2s = h2;

  logic             v3;
  logic [QuotW-1:0] qa, qb;
  hdr_t             h3;
  cbn_div_pipe u_div (
    .clk_i, .rst_ni, .valid_i(v2), .root_i(root | RootW'(h2.degen)),
    .mag_a_i(mag_a), .mag_b_i(mag_b), .hdr_i(h2s),
    .valid_o(v3), .quot_a_o(qa), .quot_b_o(qb), .hdr_o(h3)
  );

  // stage a: saturate tangent a
  logic v4_q;
  hdr_t h4_q;
  field_t ax_q, ay_q, az_q;
  field_t sa, sb;
  assign sa = sat_quot(sgn_q[DivNumW][1], qa);
  assign sb = sat_quot(sgn_q[DivNumW][0], qb);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else v4_q <= v3;
  end
  always_ff @(posedge clk_i) begin
    h4_q <= h3;
    if (h3.degen) begin
      ax_q <= '0; ay_q <= '0; az_q <= '0;
    end else begin
      ax_q <= h3.use_x ? sa : '0;
      ay_q <= h3.use_x ? '0 : sa;
      az_q <= sb;
    end
  end

  // stage b: six products
  logic v5_q;
  hdr_t h5_q;
  field_t ax5_q, ay5_q, az5_q;
  logic signed [SqW-1:0] p_yaz_q, p_zay_q, p_zax_q, p_xaz_q, p_xay_q, p_yax_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else v5_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    h5_q  <= h4_q;
    ax5_q <= ax_q; ay5_q <= ay_q; az5_q <= az_q;
    p_yaz_q <= h4_q.ny * az_q;
    p_zay_q <= h4_q.nz * ay_q;
    p_zax_q <= h4_q.nz * ax_q;
    p_xaz_q <= h4_q.nx * az_q;
    p_xay_q <= h4_q.nx * ay_q;
    p_yax_q <= h4_q.ny * ax_q;
  end

  // stage c: difference, floor shift, saturate
  logic signed [ProdW-1:0] dx, dy, dz;
  logic signed [ProdW-FracBits-1:0] sx, sy, sz;
  assign dx = ProdW'(p_yaz_q) - ProdW'(p_zay_q);
  assign dy = ProdW'(p_zax_q) - ProdW'(p_xaz_q);
  assign dz = ProdW'(p_xay_q) - ProdW'(p_yax_q);
  assign sx = dx[ProdW-1:FracBits];
  assign sy = dy[ProdW-1:FracBits];
  assign sz = dz[ProdW-1:FracBits];

  function automatic field_t sat_s(input logic signed [ProdW-FracBits-1:0] v);
    if (v > $signed((ProdW-FracBits)'(FieldMax))) sat_s = FieldMax;
    else if (v < -$signed((ProdW-FracBits)'(2 ** (FieldW-1)))) sat_s = FieldMin;
    else sat_s = field_t'(v);
  endfunction

  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= v5_q;
  end
  always_ff @(posedge clk_i) begin
    tan_a_x_o    <= ax5_q;
    tan_a_y_o    <= ay5_q;
    tan_a_z_o    <= az5_q;
    tan_b_x_o    <= sat_s(sx);
    tan_b_y_o    <= sat_s(sy);
    tan_b_z_o    <= sat_s(sz);
    degenerate_o <= h5_q.degen;
  end
  assign done_o = done_q;

  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && degenerate_o |-> tan_a_x_o == '0 && tan_b_z_o == '0)
    else $error("degenerate result not zero");
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q |=> done_o)
    else $error("result strobe lost");
endmodule

>>> bench/tb.sv
// testbench for contact_basis_from_normal_unit: table of directed normals, then random normals
// each request is predicted in place and checked in order against the done_o strobe
// depends on cbn_pkg and the unit rtl
module tb;
  import cbn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    field_t ax, ay, az, bx, by, bz;
    logic   degen;
  } basis_t;

  typedef struct {
    field_t nx, ny, nz;
    logic   known;
    basis_t res;
  } vec_row_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  field_t normal_x_i = '0, normal_y_i = '0, normal_z_i = '0;
  logic   done_o;
  field_t tan_a_x_o, tan_a_y_o, tan_a_z_o, tan_b_x_o, tan_b_y_o, tan_b_z_o;
  logic   degenerate_o;

  basis_t basis_q[$];
  int     errors = 0;

  contact_basis_from_normal_unit dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic longint floor_sqrt(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint clamp18(longint v);
    if (v > 131071) return 131071;
    if (v < -131072) return -131072;
    return v;
  endfunction

  function automatic longint unit_div(longint raw, longint root);
    longint q;
    q = ((raw < 0 ? -raw : raw) << FracBits) / root;
    return clamp18(raw < 0 ? -q : q);
  endfunction

  function automatic longint floor_shift(longint v);
    return v >>> FracBits;
  endfunction

  function automatic basis_t tangent_basis(field_t fx, field_t fy, field_t fz);
    longint x, y, z, ax, ay, az, root;
    basis_t b;
    x = fx; y = fy; z = fz;
    ax = 0; ay = 0; az = 0;
    b = '0;
    if (x == 0 && y == 0 && z == 0) begin
      b.degen = 1'b1;
      return b;
    end
    if ((x < 0 ? -x : x) > (y < 0 ? -y : y)) begin
      root = floor_sqrt(z * z + x * x);
      ax = unit_div(z, root);
      az = unit_div(-x, root);
    end else begin
      root = floor_sqrt(z * z + y * y);
      ay = unit_div(-z, root);
      az = unit_div(y, root);
    end
    b.ax = field_t'(ax); b.ay = field_t'(ay); b.az = field_t'(az);
    b.bx = field_t'(clamp18(floor_shift(y * az - z * ay)));
    b.by = field_t'(clamp18(floor_shift(z * ax - x * az)));
    b.bz = field_t'(clamp18(floor_shift(x * ay - y * ax)));
    return b;
  endfunction

  task automatic send_normal(field_t x, field_t y, field_t z, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    normal_x_i <= x; normal_y_i <= y; normal_z_i <= z;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (start && !busy && rst_ni) basis_q.push_back(tangent_basis(normal_x_i, normal_y_i,
                                                                    normal_z_i));
  end

  always @(posedge clk_i) begin
    basis_t got, want;
    if (rst_ni && done_o) begin
      got = '{tan_a_x_o, tan_a_y_o, tan_a_z_o, tan_b_x_o, tan_b_y_o, tan_b_z_o,
              degenerate_o};
      if (basis_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        errors++;
      end else begin
        want = basis_q.pop_front();
        if (got !== want) begin
          $display("%0t mismatch expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    end
  end

  // the predictor must flag a zero normal as degenerate; checked here per accepted request
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy && normal_x_i == 0 && normal_y_i == 0 && normal_z_i == 0
        && tangent_basis(normal_x_i, normal_y_i, normal_z_i).degen !== 1'b1) begin
      $display("%0t degenerate expected 1 actual %b", $time,
               tangent_basis(normal_x_i, normal_y_i, normal_z_i).degen);
      errors++;
    end
  end

  initial begin
    vec_row_t rows[$];
    int idle;
    field_t one;
    one = field_t'(1 << FracBits);
    rows = '{
      '{0, 0, 0, 1'b1, '{0, 0, 0, 0, 0, 0, 1'b1}},
      '{0, 0, one, 1'b1, '{0, -one, 0, one, 0, 0, 1'b0}},
      '{one, 0, 0, 1'b1, '{0, 0, -one, 0, one, 0, 1'b0}},
      '{0, one, 0, 1'b1, '{0, 0, one, one, 0, 0, 1'b0}},
      '{FieldMax, FieldMax, FieldMax, 1'b0, '0},
      '{FieldMin, FieldMin, FieldMin, 1'b0, '0},
      '{FieldMin, FieldMax, 0, 1'b0, '0},
      '{FieldMax, FieldMin, 1, 1'b0, '0},
      '{1, 1, 0, 1'b0, '0},
      '{-1, 1, 1, 1'b0, '0},
      '{1, 0, 0, 1'b0, '0},
      '{0, -1, 0, 1'b0, '0},
      '{0, 0, -1, 1'b0, '0},
      '{0, 0, FieldMin, 1'b0, '0},
      '{FieldMin, 0, 1, 1'b0, '0},
      '{1, FieldMin, FieldMax, 1'b0, '0},
      '{46341, -46341, 46340, 1'b0, '0},
      '{-3, 2, FieldMax, 1'b0, '0}
    };
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) begin
      if (rows[i].known && tangent_basis(rows[i].nx, rows[i].ny, rows[i].nz) !== rows[i].res)
      begin
        $display("%0t table row %0d expected %h actual %h", $time, i, rows[i].res,
                 tangent_basis(rows[i].nx, rows[i].ny, rows[i].nz));
        errors++;
      end
      send_normal(rows[i].nx, rows[i].ny, rows[i].nz, 0);
    end
    for (int n = 0; n < 1700; n++) begin
      field_t x, y, z;
      int scale;
      idle = n < 560 ? 37 : (n < 1120 ? 71 : 0);
      if ($urandom_range(19) == 0) idle = 0;
      scale = $urandom_range(3);
      x = field_t'($urandom);
      y = field_t'($urandom);
      z = field_t'($urandom);
      if (scale == 0) begin
        x = x >>> 2; y = y >>> 2; z = z >>> 2;
      end else if (scale == 1) begin
        x = x >>> 12; y = y >>> 12; z = z >>> 12;
      end
      if ($urandom_range(15) == 0) x = 0;
      if ($urandom_range(15) == 0) y = 0;
      if ($urandom_range(15) == 0) y = ($urandom_range(1) ? x : -x);
      if ($urandom_range(63) == 0) begin
        x = 0; y = 0; z = 0;
      end
      send_normal(x, y, z, idle);
    end
    start <= 1'b0;
    while (basis_q.size() != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
